### design/met_pkg.sv
// shared types, constants and saturation helper for the escape-time block
`timescale 1ns / 1ps
package met_pkg;

  localparam int LANES     = 8;
  localparam int WORD_W    = 32;
  localparam int UQ_W      = 31;
  localparam int INV_W     = 29;
  localparam int ITER_W    = 16;
  localparam int SHADE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SAT_W     = 72;
  localparam int SETUP_LAT = 6;
  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE   = 3'd0,
    REG_SHIFT_X = 3'd1,
    REG_SHIFT_Y = 3'd2,
    REG_INV_W   = 3'd3,
    REG_INV_H   = 3'd4,
    REG_ASPECT  = 3'd5,
    REG_LIMIT   = 3'd6
  } cfg_reg_t;

  // per-cycle commands from the sequencer to every lane
  typedef struct packed {
    logic init;
    logic upd;
    logic check;
    logic advance;
    logic div_load;
    logic div_step;
  } lane_ctl_t;

  // clamp a wide signed value into the 32-bit range
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] vmax;
    logic signed [SAT_W-1:0] vmin;
    vmax = 72'sd2147483647;
    vmin = -72'sd2147483648;
    if (v > vmax) begin
      return 32'sh7fffffff;
    end else if (v < vmin) begin
      return 32'sh80000000;
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

### design/mandelbrot_escape_time_eight_lane.sv
// top level: config registers, sequencer, eight lanes and result register
//
// Usage: a transaction on the in_ channel carries a group of eight adjacent
// pixels (first column and row). Each pixel is mapped to a point c in Q4.28,
// iterated z = z^2 + c from z = c, and its escape count turned into a Q0.16
// shade. One result transaction on the out_ channel follows per input, in order,
// echoing the column and row with shades for the eight pixels.
// The cfg_ channel writes the seven view registers; cfg_ready is always high,
// and writes are expected only while no group is in flight.
// Each iteration step has two phases: the registered z products, then the z
// update and escape compare; the loop runs up to the iteration limit and ends
// early once all eight lanes have escaped. The group is handled by all eight
// lanes at once; a coordinate mapping precedes the loop and a restoring
// divider in each lane follows it. One group is worked on at a time, so a new
// group is taken only after the previous one has been handed to the output
// register.
// Reset (synchronous, rst_n low) restores the register defaults and empties
// the block. If the receiver stalls, the finished result stays in the output
// register; one more group is taken and processed meanwhile, and it waits
// until the output register is free.
`timescale 1ns / 1ps
module mandelbrot_escape_time_eight_lane #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [COORD_BITS-1:0]               in_col_base,
  input  logic [COORD_BITS-1:0]               in_row,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COORD_BITS-1:0]               out_col_base,
  output logic [COORD_BITS-1:0]               out_row,
  output logic [met_pkg::SHADE_W-1:0]         out_shade0,
  output logic [met_pkg::SHADE_W-1:0]         out_shade1,
  output logic [met_pkg::SHADE_W-1:0]         out_shade2,
  output logic [met_pkg::SHADE_W-1:0]         out_shade3,
  output logic [met_pkg::SHADE_W-1:0]         out_shade4,
  output logic [met_pkg::SHADE_W-1:0]         out_shade5,
  output logic [met_pkg::SHADE_W-1:0]         out_shade6,
  output logic [met_pkg::SHADE_W-1:0]         out_shade7,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [met_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [met_pkg::WORD_W-1:0]          cfg_data
);
  import met_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_MUL, S_UPD, S_DIVL, S_DIV, S_DONE
  } state_t;

  // configuration registers
  logic [UQ_W-1:0]          scale_r, aspect_r;
  logic signed [WORD_W-1:0] shift_x_r, shift_y_r;
  logic [INV_W-1:0]         inv_w_r, inv_h_r;
  logic [ITER_W-1:0]        limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= 31'd1073741824;
      shift_x_r <= '0;
      shift_y_r <= '0;
      inv_w_r   <= 29'd262144;
      inv_h_r   <= 29'd262144;
      aspect_r  <= 31'd268435456;
      limit_r   <= 16'd256;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCALE:   scale_r   <= cfg_data[UQ_W-1:0];
        REG_SHIFT_X: shift_x_r <= cfg_data;
        REG_SHIFT_Y: shift_y_r <= cfg_data;
        REG_INV_W:   inv_w_r   <= cfg_data[INV_W-1:0];
        REG_INV_H:   inv_h_r   <= cfg_data[INV_W-1:0];
        REG_ASPECT:  aspect_r  <= cfg_data[UQ_W-1:0];
        REG_LIMIT:   limit_r   <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t               state_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [ITER_W-1:0]    k_r;
  logic [COORD_BITS-1:0] col_r, row_r;
  logic                 out_valid_r;
  logic [COORD_BITS-1:0] out_col_r, out_row_r;
  logic [SHADE_W-1:0]   out_shade_r [LANES];

  lane_ctl_t            ctl;
  logic [LANES-1:0]     live;
  logic [SHADE_W-1:0]   shade [LANES];
  logic signed [WORD_W-1:0] cy;
  logic                 any_live;

  assign any_live = |live;
  assign in_ready = (state_r == S_IDLE);

  // lane commands decoded from the sequencer state
  always_comb begin
    ctl.init     = (state_r == S_SETUP) && (cnt_r == CNT_W'(SETUP_LAT - 1));
    ctl.upd      = (state_r == S_UPD);
    ctl.check    = (k_r != '0);
    ctl.advance  = (k_r != limit_r);
    ctl.div_load = (state_r == S_DIVL);
    ctl.div_step = (state_r == S_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: set on hand-off, cleared when the receiver takes it
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            col_r   <= in_col_base;
            row_r   <= in_row;
            cnt_r   <= '0;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SETUP_LAT - 1)) begin
            k_r     <= '0;
            state_r <= (limit_r == '0) ? S_DIVL : S_MUL;
          end
        end
        S_MUL: begin
          state_r <= any_live ? S_UPD : S_DIVL;
        end
        S_UPD: begin
          if (k_r == limit_r) begin
            state_r <= S_DIVL;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DIVL: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_col_r   <= col_r;
            out_row_r   <= row_r;
            for (int i = 0; i < LANES; i++) begin
              out_shade_r[i] <= shade[i];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // shared row mapping
  met_ymap #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ymap (
    .clk        (clk),
    .row        (row_r),
    .inv_height (inv_h_r),
    .scale      (scale_r),
    .shift_y    (shift_y_r),
    .cy         (cy)
  );

  // pixel lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [COORD_BITS:0] lane_col;
    assign lane_col = {1'b0, col_r} + (COORD_BITS + 1)'(g);

    met_lane #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .col       (lane_col),
      .inv_width (inv_w_r),
      .aspect    (aspect_r),
      .scale     (scale_r),
      .shift_x   (shift_x_r),
      .cy        (cy),
      .limit     (limit_r),
      .live      (live[g]),
      .shade     (shade[g])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_col_base = out_col_r;
  assign out_row      = out_row_r;
  assign out_shade0   = out_shade_r[0];
  assign out_shade1   = out_shade_r[1];
  assign out_shade2   = out_shade_r[2];
  assign out_shade3   = out_shade_r[3];
  assign out_shade4   = out_shade_r[4];
  assign out_shade5   = out_shade_r[5];
  assign out_shade6   = out_shade_r[6];
  assign out_shade7   = out_shade_r[7];

`ifndef SYNTHESIS
  // a new result only appears from the hand-off state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside hand-off");

  // the step counter never runs past the iteration limit
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (k_r <= limit_r))
    else $error("step counter beyond limit");

  // a waiting result is only dropped when the receiver takes it
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready))
    else $error("result dropped without a transaction");
`endif

endmodule

### design/met_ymap.sv
// row to imaginary coordinate mapping, shared by all lanes
`timescale 1ns / 1ps
module met_ymap #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  logic                              clk,
  input  logic [COORD_BITS-1:0]             row,
  input  logic [met_pkg::INV_W-1:0]         inv_height,
  input  logic [met_pkg::UQ_W-1:0]          scale,
  input  logic signed [met_pkg::WORD_W-1:0] shift_y,
  output logic signed [met_pkg::WORD_W-1:0] cy
);
  import met_pkg::*;

  localparam int MW = COORD_BITS + INV_W;
  localparam logic signed [SAT_W-1:0] HALF = SAT_W'(1) << (FRAC_BITS - 1);

  logic [MW-1:0]               m1;
  logic signed [2*WORD_W-1:0]  p3;
  logic signed [2*WORD_W-1:0]  p3s;
  logic signed [WORD_W-1:0]    t1_r, t2_r, t3_r, cy_r;

  assign m1  = {{INV_W{1'b0}}, row} * {{COORD_BITS{1'b0}}, inv_height};
  assign p3  = t2_r * $signed({1'b0, scale});
  assign p3s = p3 >>> FRAC_BITS;

  // four registered stages, refreshed every cycle from held operands
  always_ff @(posedge clk) begin
    t1_r <= sat32(SAT_W'(m1));
    t2_r <= sat32(SAT_W'(t1_r) - HALF);
    t3_r <= sat32(SAT_W'(p3s));
    cy_r <= sat32(SAT_W'(t3_r) + SAT_W'(shift_y));
  end

  assign cy = cy_r;

endmodule

### design/met_lane.sv
// one pixel lane: column mapping, z^2+c iteration and shade divider
`timescale 1ns / 1ps
module met_lane #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  met_pkg::lane_ctl_t                ctl,
  input  logic [COORD_BITS:0]               col,
  input  logic [met_pkg::INV_W-1:0]         inv_width,
  input  logic [met_pkg::UQ_W-1:0]          aspect,
  input  logic [met_pkg::UQ_W-1:0]          scale,
  input  logic signed [met_pkg::WORD_W-1:0] shift_x,
  input  logic signed [met_pkg::WORD_W-1:0] cy,
  input  logic [met_pkg::ITER_W-1:0]        limit,
  output logic                              live,
  output logic [met_pkg::SHADE_W-1:0]       shade
);
  import met_pkg::*;

  localparam int MW = COORD_BITS + 1 + INV_W;
  localparam int PW = 2 * WORD_W - FRAC_BITS + 2;
  localparam logic signed [SAT_W-1:0] HALF = SAT_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0]    FOUR = PW'(1) << (FRAC_BITS + 2);

  // column mapping
  logic [MW-1:0]              m1;
  logic signed [2*WORD_W-1:0] p2, p2s, p4, p4s;
  logic signed [WORD_W-1:0]   s1_r, s2_r, s3_r, s4_r, cx_r;

  assign m1  = {{INV_W{1'b0}}, col} * {{(COORD_BITS + 1){1'b0}}, inv_width};
  assign p2  = s1_r * $signed({1'b0, aspect});
  assign p2s = p2 >>> FRAC_BITS;
  assign p4  = s3_r * $signed({1'b0, scale});
  assign p4s = p4 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    s1_r <= sat32(SAT_W'(m1));
    s2_r <= sat32(SAT_W'(p2s));
    s3_r <= sat32(SAT_W'(s2_r) - HALF);
    s4_r <= sat32(SAT_W'(p4s));
    cx_r <= sat32(SAT_W'(s4_r) + SAT_W'(shift_x));
  end

  // products of the current z, registered every cycle
  logic signed [WORD_W-1:0]   zx_r, zy_r;
  logic signed [2*WORD_W-1:0] pxx_r, pyy_r, pxy_r;
  logic signed [2*WORD_W-1:0] sxx, syy, sxy;
  logic signed [PW-1:0]       xx, yy, xy, mag, sum_x, sum_y;
  logic                       esc;

  always_ff @(posedge clk) begin
    pxx_r <= zx_r * zx_r;
    pyy_r <= zy_r * zy_r;
    pxy_r <= zx_r * zy_r;
  end

  assign sxx   = pxx_r >>> FRAC_BITS;
  assign syy   = pyy_r >>> FRAC_BITS;
  assign sxy   = pxy_r >>> FRAC_BITS;
  assign xx    = sxx[PW-1:0];
  assign yy    = syy[PW-1:0];
  assign xy    = sxy[PW-1:0];
  assign mag   = xx + yy;
  assign esc   = (mag >= FOUR);
  assign sum_x = xx - yy + PW'(cx_r);
  assign sum_y = (xy <<< 1) + PW'(cy);

  // lane state: alive flag and iteration count
  logic [ITER_W-1:0] count_r;
  logic              live_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= 1'b0;
      count_r <= '0;
    end else if (ctl.init) begin
      live_r  <= 1'b1;
      count_r <= '0;
    end else if (ctl.upd && live_r && ctl.check) begin
      if (esc) begin
        live_r <= 1'b0;
      end else begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // z update, frozen once the lane has escaped and at the iteration limit
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      zx_r <= cx_r;
      zy_r <= cy;
    end else if (ctl.upd && live_r && ctl.advance && !(ctl.check && esc)) begin
      zx_r <= sat32(SAT_W'(sum_x));
      zy_r <= sat32(SAT_W'(sum_y));
    end
  end

  // restoring divider, count*65536 / limit, one quotient bit a cycle
  logic [ITER_W:0]    rem_r, rem_sh;
  logic [SHADE_W-1:0] quo_r;

  assign rem_sh = {rem_r[ITER_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      rem_r <= {1'b0, count_r};
      quo_r <= '0;
    end else if (ctl.div_step) begin
      if (rem_sh >= {1'b0, limit}) begin
        rem_r <= rem_sh - {1'b0, limit};
        quo_r <= {quo_r[SHADE_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[SHADE_W-2:0], 1'b0};
      end
    end
  end

  assign live  = live_r;
  assign shade = (count_r == limit) ? '0 : quo_r;

endmodule
